>>> hdl/lslf_pkg.sv
// Shared widths, types, codes and helper functions for the line fit core.
package lslf_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int X_WIDTH    = 16;
    localparam int Y_WIDTH    = 32;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int SX_W       = X_WIDTH + CNT_W;
    localparam int SY_W       = Y_WIDTH + CNT_W - 1;
    localparam int SXY_W      = X_WIDTH + Y_WIDTH + CNT_W - 1;
    localparam int SXX_W      = 2 * X_WIDTH + CNT_W - 1;
    localparam int MATH_W     = SXY_W + CNT_W + 3;
    localparam int MB_W       = (SX_W > Y_WIDTH) ? SX_W : Y_WIDTH;
    localparam int DIV_CW     = $clog2(MATH_W + 1);
    localparam int Q_DEPTH    = 2;
    localparam int QP_W       = $clog2(Q_DEPTH);
    localparam int QC_W       = $clog2(Q_DEPTH + 1);

    localparam logic signed [MATH_W-1:0] Q_MAX = {{(MATH_W-32){1'b0}}, 32'h7fff_ffff};
    localparam logic signed [MATH_W-1:0] Q_MIN = {{(MATH_W-32){1'b1}}, 32'h8000_0000};

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_DEGEN = 2'd1,
        STAT_SAT   = 2'd2,
        STAT_MANY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_ISSUE,
        BS_MUL,
        BS_DIV
    } t_bstate;

    typedef enum logic [2:0] {
        SP_NSXY,
        SP_SXSY,
        SP_NSXX,
        SP_SXSX,
        SP_SLOPE,
        SP_MEAN,
        SP_SLSX,
        SP_ICPT
    } t_step;

    // Finished sums of one data set.
    typedef struct packed {
        logic                    ovf;
        logic [CNT_W-1:0]        n;
        logic signed [SX_W-1:0]  sx;
        logic signed [SY_W-1:0]  sy;
        logic signed [SXY_W-1:0] sxy;
        logic [SXX_W-1:0]        sxx;
    } t_snap;

    function automatic logic [MATH_W-1:0] abs_w(input logic signed [MATH_W-1:0] v);
        abs_w = v[MATH_W-1] ? MATH_W'(-v) : MATH_W'(v);
    endfunction

    function automatic logic is_sat(input logic signed [MATH_W-1:0] v);
        is_sat = (v > Q_MAX) || (v < Q_MIN);
    endfunction

    function automatic logic signed [31:0] sat_q(input logic signed [MATH_W-1:0] v);
        if (v > Q_MAX) begin
            sat_q = 32'sh7fff_ffff;
        end else if (v < Q_MIN) begin
            sat_q = 32'sh8000_0000;
        end else begin
            sat_q = v[31:0];
        end
    endfunction

endpackage

>>> hdl/lslf_queue.sv
// Short queue of finished data set sums between the front and the solver.
module lslf_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  lslf_pkg::t_snap        i_data,
    input  logic                   i_rd,
    output lslf_pkg::t_snap        o_data,
    output logic                   o_empty,
    output logic [lslf_pkg::QC_W-1:0] o_count
);

    lslf_pkg::t_snap r_mem [lslf_pkg::Q_DEPTH];
    logic [lslf_pkg::QP_W-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [lslf_pkg::QC_W-1:0] r_cnt, n_cnt;

    function automatic logic [lslf_pkg::QP_W-1:0] QP_NEXT(input logic [lslf_pkg::QP_W-1:0] p);
        QP_NEXT = (p == lslf_pkg::QP_W'(lslf_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr) begin
            n_wp = QP_NEXT(r_wp);
        end
        if (i_rd) begin
            n_rp = QP_NEXT(r_rp);
        end
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_rd && !i_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

>>> hdl/lslf_front.sv
// Front end: takes points, forms products, accumulates sums, hands off each data set.
module lslf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [15:0]               i_x_value,
    input  logic [31:0]               i_y_value,
    input  logic                      i_last_point,
    input  logic [lslf_pkg::QC_W-1:0] i_q_count,
    output logic                      o_full,
    output logic                      o_q_wr,
    output lslf_pkg::t_snap           o_q_data
);

    localparam int XY_W = lslf_pkg::X_WIDTH + lslf_pkg::Y_WIDTH;
    localparam int XX_W = 2 * lslf_pkg::X_WIDTH;

    logic                                r_v, r_last;
    logic signed [lslf_pkg::X_WIDTH-1:0] r_x;
    logic signed [lslf_pkg::Y_WIDTH-1:0] r_y;
    logic signed [XY_W-1:0]              r_xy;
    logic [XX_W-1:0]                     r_xx;

    logic signed [lslf_pkg::X_WIDTH-1:0] x_in;
    logic signed [lslf_pkg::Y_WIDTH-1:0] y_in;
    logic signed [XY_W-1:0]              xy_in;
    logic signed [XX_W-1:0]              xx_in;
    logic                                accept;

    logic                                  r_ovf, n_ovf;
    logic [lslf_pkg::CNT_W-1:0]            r_n, n_n;
    logic signed [lslf_pkg::SX_W-1:0]      r_sx, n_sx;
    logic signed [lslf_pkg::SY_W-1:0]      r_sy, n_sy;
    logic signed [lslf_pkg::SXY_W-1:0]     r_sxy, n_sxy;
    logic [lslf_pkg::SXX_W-1:0]            r_sxx, n_sxx;
    logic [lslf_pkg::QC_W:0]               room_use;

    // Count sets already queued plus one still in flight.
    assign room_use = (lslf_pkg::QC_W+1)'(i_q_count) + (lslf_pkg::QC_W+1)'(r_v && r_last);
    assign o_full   = (room_use >= (lslf_pkg::QC_W+1)'(lslf_pkg::Q_DEPTH));
    assign accept   = i_push && !o_full;

    assign x_in  = i_x_value[lslf_pkg::X_WIDTH-1:0];
    assign y_in  = i_y_value;
    assign xy_in = XY_W'(x_in) * XY_W'(y_in);
    assign xx_in = XX_W'(x_in) * XX_W'(x_in);

    always_comb begin
        n_ovf = r_ovf;
        n_n   = r_n;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_sxy = r_sxy;
        n_sxx = r_sxx;
        if (r_v) begin
            if (r_n < lslf_pkg::CNT_W'(lslf_pkg::MAX_POINTS)) begin
                n_n   = r_n + 1'b1;
                n_sx  = r_sx + lslf_pkg::SX_W'(r_x);
                n_sy  = r_sy + lslf_pkg::SY_W'(r_y);
                n_sxy = r_sxy + lslf_pkg::SXY_W'(r_xy);
                n_sxx = r_sxx + lslf_pkg::SXX_W'(r_xx);
            end else begin
                n_ovf = 1'b1;
            end
        end
        o_q_wr         = r_v && r_last;
        o_q_data.ovf   = n_ovf;
        o_q_data.n     = n_n;
        o_q_data.sx    = n_sx;
        o_q_data.sy    = n_sy;
        o_q_data.sxy   = n_sxy;
        o_q_data.sxx   = n_sxx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_ovf <= 1'b0;
            r_n   <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxy <= '0;
            r_sxx <= '0;
        end else begin
            r_v <= accept;
            if (o_q_wr) begin
                r_ovf <= 1'b0;
                r_n   <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_sxy <= '0;
                r_sxx <= '0;
            end else begin
                r_ovf <= n_ovf;
                r_n   <= n_n;
                r_sx  <= n_sx;
                r_sy  <= n_sy;
                r_sxy <= n_sxy;
                r_sxx <= n_sxx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last <= i_last_point;
            r_x    <= x_in;
            r_y    <= y_in;
            r_xy   <= xy_in;
            r_xx   <= XX_W'(xx_in);
        end
    end

endmodule

>>> hdl/lslf_back.sv
// Solver: shift-add multiplier and restoring divider sequenced over one data set.
module lslf_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  lslf_pkg::t_snap        i_q_data,
    output logic                   o_q_rd,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [31:0]            o_slope,
    output logic [31:0]            o_intercept,
    output logic [1:0]             o_status
);

    localparam int MW = lslf_pkg::MATH_W;

    lslf_pkg::t_bstate r_state, n_state;
    lslf_pkg::t_step   r_step, n_step;
    lslf_pkg::t_snap   r_snap, n_snap;

    logic signed [MW-1:0] r_num, n_num, r_den, n_den;
    logic signed [31:0]   r_slope, n_slope;
    logic                 r_sat, n_sat;
    logic [MW-1:0]        r_ma, n_ma, r_acc, n_acc;
    logic [lslf_pkg::MB_W-1:0] r_mb, n_mb;
    logic                 r_neg, n_neg;
    logic [MW-1:0]        r_dq, n_dq, r_rem, n_rem, r_dd, n_dd;
    logic [lslf_pkg::DIV_CW-1:0] r_cnt, n_cnt;

    logic                 r_ov, n_ov;
    logic [31:0]          r_os, n_os, r_oi, n_oi;
    logic [1:0]           r_ost, n_ost;

    logic signed [MW-1:0] e_n, e_sx, e_sy, e_sxy, e_sxx, op_a, op_b, res;
    logic [MW-1:0]        mag_a, mag_b;
    logic                 op_div, finish;
    logic [MW:0]          rem2;
    logic                 ge;

    assign e_n   = MW'(signed'({1'b0, r_snap.n}));
    assign e_sx  = MW'(r_snap.sx);
    assign e_sy  = MW'(r_snap.sy);
    assign e_sxy = MW'(r_snap.sxy);
    assign e_sxx = MW'(signed'({1'b0, r_snap.sxx}));

    assign rem2 = {r_rem, r_dq[MW-1]};
    assign ge   = (rem2 >= {1'b0, r_dd});

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_snap  = r_snap;
        n_num   = r_num;
        n_den   = r_den;
        n_slope = r_slope;
        n_sat   = r_sat;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_dq    = r_dq;
        n_rem   = r_rem;
        n_dd    = r_dd;
        n_cnt   = r_cnt;
        n_ov    = r_ov && !i_pop;
        n_os    = r_os;
        n_oi    = r_oi;
        n_ost   = r_ost;
        o_q_rd  = 1'b0;
        op_a    = '0;
        op_b    = '0;
        op_div  = 1'b0;
        finish  = 1'b0;
        res     = '0;
        mag_a   = '0;
        mag_b   = '0;

        unique case (r_state)
            lslf_pkg::BS_IDLE: begin
                if (!i_q_empty && !r_ov) begin
                    o_q_rd = 1'b1;
                    n_snap = i_q_data;
                    n_sat  = 1'b0;
                    if (i_q_data.ovf || i_q_data.n == '0) begin
                        n_ov  = 1'b1;
                        n_os  = '0;
                        n_oi  = '0;
                        n_ost = lslf_pkg::STAT_MANY;
                    end else begin
                        n_step  = lslf_pkg::SP_NSXY;
                        n_state = lslf_pkg::BS_ISSUE;
                    end
                end
            end
            lslf_pkg::BS_ISSUE: begin
                unique case (r_step)
                    lslf_pkg::SP_NSXY: begin
                        op_a = e_sxy;
                        op_b = e_n;
                    end
                    lslf_pkg::SP_SXSY: begin
                        op_a = e_sy;
                        op_b = e_sx;
                    end
                    lslf_pkg::SP_NSXX: begin
                        op_a = e_sxx;
                        op_b = e_n;
                    end
                    lslf_pkg::SP_SXSX: begin
                        op_a = e_sx;
                        op_b = e_sx;
                    end
                    lslf_pkg::SP_SLOPE: begin
                        op_div = 1'b1;
                        if (r_den == '0) begin
                            n_step = lslf_pkg::SP_MEAN;
                            op_a   = e_sy;
                            op_b   = e_n;
                        end else begin
                            op_a = r_num;
                            op_b = r_den;
                        end
                    end
                    lslf_pkg::SP_MEAN: begin
                        op_div = 1'b1;
                        op_a   = e_sy;
                        op_b   = e_n;
                    end
                    lslf_pkg::SP_SLSX: begin
                        op_a = MW'(r_slope);
                        op_b = e_sx;
                    end
                    lslf_pkg::SP_ICPT: begin
                        op_div = 1'b1;
                        op_a   = r_num;
                        op_b   = e_n;
                    end
                endcase
                mag_a = lslf_pkg::abs_w(op_a);
                mag_b = lslf_pkg::abs_w(op_b);
                n_neg = op_a[MW-1] ^ op_b[MW-1];
                if (op_div) begin
                    // Add half the divisor for round to nearest, ties away from zero.
                    n_dq    = mag_a + (mag_b >> 1);
                    n_dd    = mag_b;
                    n_rem   = '0;
                    n_cnt   = lslf_pkg::DIV_CW'(MW);
                    n_state = lslf_pkg::BS_DIV;
                end else begin
                    n_ma    = mag_a;
                    n_mb    = mag_b[lslf_pkg::MB_W-1:0];
                    n_acc   = '0;
                    n_state = lslf_pkg::BS_MUL;
                end
            end
            lslf_pkg::BS_MUL: begin
                if (r_mb == '0) begin
                    finish = 1'b1;
                    res    = r_neg ? -signed'(r_acc) : signed'(r_acc);
                end else begin
                    n_acc = r_mb[0] ? r_acc + r_ma : r_acc;
                    n_ma  = r_ma << 1;
                    n_mb  = r_mb >> 1;
                end
            end
            lslf_pkg::BS_DIV: begin
                if (r_cnt == '0) begin
                    finish = 1'b1;
                    res    = r_neg ? -signed'(r_dq) : signed'(r_dq);
                end else begin
                    n_rem = ge ? MW'(rem2 - {1'b0, r_dd}) : MW'(rem2);
                    n_dq  = {r_dq[MW-2:0], ge};
                    n_cnt = r_cnt - 1'b1;
                end
            end
        endcase

        if (finish) begin
            n_state = lslf_pkg::BS_ISSUE;
            unique case (r_step)
                lslf_pkg::SP_NSXY: begin
                    n_num  = res;
                    n_step = lslf_pkg::SP_SXSY;
                end
                lslf_pkg::SP_SXSY: begin
                    n_num  = r_num - res;
                    n_step = lslf_pkg::SP_NSXX;
                end
                lslf_pkg::SP_NSXX: begin
                    n_den  = res;
                    n_step = lslf_pkg::SP_SXSX;
                end
                lslf_pkg::SP_SXSX: begin
                    n_den  = r_den - res;
                    n_step = lslf_pkg::SP_SLOPE;
                end
                lslf_pkg::SP_SLOPE: begin
                    n_slope = lslf_pkg::sat_q(res);
                    n_sat   = lslf_pkg::is_sat(res);
                    n_step  = lslf_pkg::SP_SLSX;
                end
                lslf_pkg::SP_SLSX: begin
                    n_num  = e_sy - res;
                    n_step = lslf_pkg::SP_ICPT;
                end
                lslf_pkg::SP_MEAN: begin
                    n_state = lslf_pkg::BS_IDLE;
                    n_ov    = 1'b1;
                    n_os    = '0;
                    n_oi    = lslf_pkg::sat_q(res);
                    n_ost   = lslf_pkg::STAT_DEGEN;
                end
                lslf_pkg::SP_ICPT: begin
                    n_state = lslf_pkg::BS_IDLE;
                    n_ov    = 1'b1;
                    n_os    = r_slope;
                    n_oi    = lslf_pkg::sat_q(res);
                    n_ost   = (r_sat || lslf_pkg::is_sat(res)) ? lslf_pkg::STAT_SAT
                                                                : lslf_pkg::STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lslf_pkg::BS_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_snap  <= n_snap;
        r_num   <= n_num;
        r_den   <= n_den;
        r_slope <= n_slope;
        r_sat   <= n_sat;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_acc   <= n_acc;
        r_neg   <= n_neg;
        r_dq    <= n_dq;
        r_rem   <= n_rem;
        r_dd    <= n_dd;
        r_cnt   <= n_cnt;
        r_os    <= n_os;
        r_oi    <= n_oi;
        r_ost   <= n_ost;
    end

    assign o_empty     = !r_ov;
    assign o_slope     = r_os;
    assign o_intercept = r_oi;
    assign o_status    = r_ost;

endmodule

>>> hdl/least_squares_line_fit_core.sv
// Top level of the least squares line fit core: front, hand-off queue, solver.
// Throughput: one point per cycle while the hand-off queue has room for a finished set.
// Hand-off: a last point reaches the queue in the cycle after its transaction; the solver then
//   works through the set with a bit-serial multiply and divide.
// Reset (synchronous, active low) clears all sums, the queue and any pending result.
module least_squares_line_fit_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [15:0] i_x_value,
    input  logic [31:0] i_y_value,
    input  logic        i_last_point,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_slope,
    output logic [31:0] o_intercept,
    output logic [1:0]  o_status
);

    // Hand-off between accumulation and solve: one entry per finished data set.
    logic                      q_wr, q_rd, q_empty;
    lslf_pkg::t_snap           q_wdata, q_rdata;
    logic [lslf_pkg::QC_W-1:0] q_count;

    // Accumulate point transactions; hold off new points when no set slot is free.
    lslf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_x_value    (i_x_value),
        .i_y_value    (i_y_value),
        .i_last_point (i_last_point),
        .i_q_count    (q_count),
        .o_full       (o_full),
        .o_q_wr       (q_wr),
        .o_q_data     (q_wdata)
    );

    lslf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_wdata),
        .i_rd    (q_rd),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    // Solve one set at a time; the result register drains through pop.
    lslf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_rd      (q_rd),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_slope     (o_slope),
        .o_intercept (o_intercept),
        .o_status    (o_status)
    );

endmodule

>>> verif/lslf_checker.sv
// Line fit checker: tracks both queue ports, predicts each fit result and compares it.
module lslf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [15:0] i_x_value,
    input  logic [31:0] i_y_value,
    input  logic        i_last_point,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [31:0] i_slope,
    input  logic [31:0] i_intercept,
    input  logic [1:0]  i_status,
    output int          o_pending,
    output int          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [31:0]       slope;
        logic [31:0]       intercept;
        lslf_pkg::t_status status;
    } t_fit;

    t_fit  fit_q[$];
    int    pt_cnt;
    t_wide acc_x, acc_y, acc_xy, acc_xx;
    logic  too_many;

    function automatic t_wide div_round(t_wide num, t_wide den);
        t_wide an, ad, q;
        an = num[127] ? -num : num;
        ad = den[127] ? -den : den;
        q  = t_wide'(($unsigned(an) + ($unsigned(ad) >> 1)) / $unsigned(ad));
        return (num[127] != den[127]) ? -q : q;
    endfunction

    function automatic t_wide clamp_q(t_wide v, inout logic sat);
        if (v > t_wide'(64'sh7fff_ffff)) begin
            sat = 1'b1;
            return t_wide'(64'sh7fff_ffff);
        end
        if (v < -t_wide'(64'sh8000_0000)) begin
            sat = 1'b1;
            return -t_wide'(64'sh8000_0000);
        end
        return v;
    endfunction

    function automatic t_fit solve_fit();
        t_fit  r;
        t_wide n, num, den, sl, ic;
        logic  sat;
        sat = 1'b0;
        n   = t_wide'(pt_cnt);
        if (too_many || pt_cnt == 0) begin
            sl = 0;
            ic = 0;
            r.status = lslf_pkg::STAT_MANY;
        end else begin
            num = n * acc_xy - acc_x * acc_y;
            den = n * acc_xx - acc_x * acc_x;
            if (den == 0) begin
                sl = 0;
                ic = clamp_q(div_round(acc_y, n), sat);
                r.status = lslf_pkg::STAT_DEGEN;
            end else begin
                sl = clamp_q(div_round(num, den), sat);
                ic = clamp_q(div_round(acc_y - sl * acc_x, n), sat);
                r.status = sat ? lslf_pkg::STAT_SAT : lslf_pkg::STAT_OK;
            end
        end
        r.slope     = sl[31:0];
        r.intercept = ic[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_fit got, want;
        t_wide xv, yv;
        if (!i_rst_n) begin
            pt_cnt   = 0;
            acc_x    = 0;
            acc_y    = 0;
            acc_xy   = 0;
            acc_xx   = 0;
            too_many = 1'b0;
            fit_q.delete();
            o_errors <= 0;
        end else begin
            // score the result transaction against the oldest prediction
            if (i_pop && !i_empty) begin
                got.slope     = i_slope;
                got.intercept = i_intercept;
                got.status    = lslf_pkg::t_status'(i_status);
                if (fit_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected result %h %h %0d", $realtime,
                                 i_slope, i_intercept, i_status);
                    o_errors <= o_errors + 1;
                end else begin
                    want = fit_q.pop_front();
                    if (got != want) begin
                        if (o_errors < 10)
                            $display("%0t: mismatch slope %h/%h icpt %h/%h status %0d/%0d",
                                     $realtime, want.slope, got.slope, want.intercept,
                                     got.intercept, want.status, got.status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            // accumulate the point transaction
            if (i_push && !i_full) begin
                xv = t_wide'($signed(i_x_value));
                yv = t_wide'($signed(i_y_value));
                if (pt_cnt < lslf_pkg::MAX_POINTS) begin
                    acc_x  += xv;
                    acc_y  += yv;
                    acc_xy += xv * yv;
                    acc_xx += xv * xv;
                    pt_cnt++;
                end else begin
                    too_many = 1'b1;
                end
                if (i_last_point) begin
                    fit_q.push_back(solve_fit());
                    pt_cnt   = 0;
                    acc_x    = 0;
                    acc_y    = 0;
                    acc_xy   = 0;
                    acc_xx   = 0;
                    too_many = 1'b0;
                end
            end
        end
        o_pending <= fit_q.size();
    end

endmodule

>>> verif/tb_top.sv
// Testbench top for the line fit core: point stimulus, result draining and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Abort after this many cycles with no transaction on either port.
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 400;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [15:0] x_value;
    logic [31:0] y_value;
    logic        last_point;
    logic        empty;
    logic        pop;
    logic [31:0] slope;
    logic [31:0] intercept;
    logic [1:0]  status;
    int          pending;
    int          errors;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;

    least_squares_line_fit_core DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_x_value    (x_value),
        .i_y_value    (y_value),
        .i_last_point (last_point),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_slope      (slope),
        .o_intercept  (intercept),
        .o_status     (status)
    );

    lslf_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_x_value    (x_value),
        .i_y_value    (y_value),
        .i_last_point (last_point),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_slope      (slope),
        .i_intercept  (intercept),
        .i_status     (status),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: decide pop at each falling edge according to the phase.
    always @(negedge clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one point; hold it until the transaction completes.
    task automatic send_point(input logic [15:0] xv, input logic [31:0] yv,
                              input logic lp);
        while ($urandom_range(99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge clk);
        end
        push       = 1'b1;
        x_value    = xv;
        y_value    = yv;
        last_point = lp;
        do @(posedge clk); while (full);
        @(negedge clk);
    endtask

    // Send one data set of random points; the x spread and y scale vary by set.
    task automatic send_set(input int pts);
        int          mode;
        logic [15:0] xv;
        logic [31:0] yv;
        mode = $urandom_range(3);
        for (int i = 0; i < pts; i++) begin
            case (mode)
                0: begin
                    xv = 16'($signed($urandom_range(40)) - 20);
                    yv = 32'($signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000);
                end
                1: begin
                    xv = 16'($signed($urandom_range(2000)) - 1000);
                    yv = $urandom;
                end
                2: begin
                    xv = 16'($urandom_range(3));
                    yv = $urandom;
                end
                default: begin
                    xv = 16'($urandom);
                    yv = $urandom;
                end
            endcase
            send_point(xv, yv, i == pts - 1);
        end
    endtask

    // Hold the sender until every predicted result has drained.
    task automatic wait_drained();
        push = 1'b0;
        while (pending != 0) @(negedge clk);
        @(negedge clk);
    endtask

    initial begin
        int sent;
        push          = 1'b0;
        x_value       = '0;
        y_value       = '0;
        last_point    = 1'b0;
        pop           = 1'b0;
        rst_n         = 1'b0;
        send_idle_pct = 35;
        recv_idle_pct = 54;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a lone point gives a degenerate fit.
        send_point(16'sh7fff, 32'sh7fff_ffff, 1'b1);
        // All x equal: degenerate with a mean y.
        send_point(16'sh8000, 32'sh8000_0000, 1'b0);
        send_point(16'sh8000, 32'sh8000_0000, 1'b0);
        send_point(16'sh8000, 32'sh7fff_ffff, 1'b1);
        // Two points on a plain line.
        send_point(16'sd0, 32'sh0001_0000, 1'b0);
        send_point(16'sd2, 32'sh0005_0000, 1'b1);
        // Steep line between adjacent x: the slope saturates.
        send_point(16'sd0, 32'sh8000_0000, 1'b0);
        send_point(16'sd1, 32'sh7fff_ffff, 1'b1);
        // Extreme x with an extreme y swing: the intercept saturates.
        send_point(16'sh7fff, 32'sh8000_0000, 1'b0);
        send_point(16'sh7ffe, 32'sh7fff_ffff, 1'b1);
        send_point(16'sh8000, 32'sh0000_0000, 1'b0);
        send_point(16'sh8001, 32'shffff_ffff, 1'b0);
        send_point(16'sh0000, 32'sh5555_5555, 1'b1);
        // Pause: let every result drain before going on.
        wait_drained();

        // Random sets in three idling phases.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 54 : 0;
            recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 35 : 0;
            sent = 0;
            while (sent < 305) begin
                int pts;
                pts = ($urandom_range(9) == 0) ? $urandom_range(40, 2)
                                               : $urandom_range(6, 1);
                send_set(pts);
                sent += pts;
                if ($urandom_range(15) == 0) wait_drained();
            end
        end
        push = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/lslf_pkg.sv
hdl/lslf_queue.sv
hdl/lslf_front.sv
hdl/lslf_back.sv
hdl/least_squares_line_fit_core.sv
verif/lslf_checker.sv
verif/tb_top.sv
